@@ hdl/circular_deque_alt_reverse_core_macros.svh @@
// Assertion helpers for the deque core.
`ifndef CIRCULAR_DEQUE_ALT_REVERSE_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_ALT_REVERSE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque core: assertion failed");

// Next-cycle implication, disabled during reset.
`define CDAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque core: assertion failed");

`endif

@@ hdl/cdar_pkg.sv @@
`default_nettype none

package cdar_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = CNT_W + 1;

  localparam int FUNC_W       = 3;
  localparam int DATA_FIELD_W = 32;
  localparam int COUNT_W      = 6;
  localparam int STATUS_W     = 2;

  typedef logic [FUNC_W-1:0]              func_t;
  typedef logic signed [DATA_FIELD_W-1:0] data_t;
  typedef logic [COUNT_W-1:0]             count_t;
  typedef logic [STATUS_W-1:0]            status_t;
  typedef logic [DATA_WIDTH-1:0]          word_t;
  typedef logic [IDX_W-1:0]               idx_t;

  localparam func_t FUNC_PUSH_FRONT = 3'd0;
  localparam func_t FUNC_PUSH_BACK  = 3'd1;
  localparam func_t FUNC_POP_FRONT  = 3'd2;
  localparam func_t FUNC_POP_BACK   = 3'd3;
  localparam func_t FUNC_REORDER    = 3'd4;
  localparam func_t FUNC_DUMP       = 3'd5;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_GATHER,
    S_COPY,
    S_DUMP
  } state_e;

  // Stored word to result field: sign-extend or truncate.
  function automatic data_t ext_word(input word_t w);
    return DATA_FIELD_W'($signed(w));
  endfunction

endpackage

`default_nettype wire

@@ hdl/cdar_ram.sv @@
`default_nettype none

module cdar_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/cdar_slot.sv @@
`default_nettype none

// Ring slot of a logical position: (front + pos) mod DEPTH.
module cdar_slot (
  input  wire cdar_pkg::idx_t front_i,
  input  wire cdar_pkg::idx_t pos_i,
  output cdar_pkg::idx_t      slot_o
);

  import cdar_pkg::*;

  logic [IDX_W:0] sum;

  always_comb begin
    sum = {1'b0, front_i} + {1'b0, pos_i};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      slot_o = IDX_W'(sum - (IDX_W + 1)'(DEPTH));
    end else begin
      slot_o = IDX_W'(sum);
    end
  end

endmodule

`default_nettype wire

@@ hdl/circular_deque_alt_reverse_core.sv @@
// Double-ended queue of signed words held as a ring in a single-port-pair RAM.
//
// Command channel: a word (func_i, value_i) is taken at a rising edge with
// start_i high and busy_o low. Results leave on data_o/count_o/status_o/last_o
// for exactly one cycle, marked by valid_o; the receiver cannot stall them,
// and the result register lets the next command come in while a result shows.
//
// Timing, n = elements held (all driven by the one ring slot adder and the
// registered read of each RAM):
//   push front/back, rejected push, empty pop/dump, short reorder, unused
//   codes: busy_o stays low, result strobes the cycle after accept.
//   pop: busy during the ring read; the read data goes through the result register.
//   dump: busy until every element is read, one result per element,
//   one per cycle from the ring reads; last_o marks the back element.
//   reorder (n > 2): n ring reads into scratch in the reordered sequence,
//   then n scratch reads copied back to slot 0 onward; each pass waits
//   for its last read to land before the walk closes.
// Reset clears front index, count and control; RAM contents stay undefined
// and are only read at live slots.
`default_nettype none
`include "circular_deque_alt_reverse_core_macros.svh"

module circular_deque_alt_reverse_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire cdar_pkg::func_t   func_i,
  input  wire cdar_pkg::data_t   value_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output cdar_pkg::data_t        data_o,
  output cdar_pkg::count_t       count_o,
  output cdar_pkg::status_t      status_o,
  output logic                   last_o
);

  import cdar_pkg::*;

  state_e state_q, state_d;

  idx_t             front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] step_q, step_d;     // walk position / reads issued
  logic [POS_W-1:0] pos_q, pos_d;       // gather: logical position
  logic             odd_q, odd_d;       // gather: in the odd, descending half
  logic             pend_q, pend_d;     // RAM read in flight
  idx_t             pidx_q, pidx_d;     // write index for the read in flight
  logic             plast_q, plast_d;

  logic    res_vld_q, res_vld_d;
  data_t   res_data_q, res_data_d;
  status_t res_st_q, res_st_d;
  logic    res_last_q, res_last_d;

  // Ring RAM and scratch RAM ports
  logic  ring_we, ring_re, scr_we, scr_re;
  idx_t  ring_waddr, ring_raddr, scr_waddr, scr_raddr;
  word_t ring_wdata, ring_rdata, scr_wdata, scr_rdata;

  // Shared slot adder
  idx_t slot_pos, slot;

  logic             accept;
  logic             full, empty, walk_done;
  logic [POS_W-1:0] cnt_ext, hi_odd;

  assign accept    = start_i && !busy_o;
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign walk_done = (step_q == count_q) && !pend_q;
  assign cnt_ext   = POS_W'(count_q);
  // Highest odd position below n
  assign hi_odd    = count_q[0] ? (cnt_ext - POS_W'(2)) : (cnt_ext - POS_W'(1));

  cdar_slot u_slot (
    .front_i (front_q),
    .pos_i   (slot_pos),
    .slot_o  (slot)
  );

  cdar_ram #(.W(DATA_WIDTH), .D(DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  cdar_ram #(.W(DATA_WIDTH), .D(DEPTH)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .re_i    (scr_re),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_POP_FRONT, FUNC_POP_BACK: if (!empty) state_d = S_POP;
            FUNC_REORDER: if (count_q > CNT_W'(2)) state_d = S_GATHER;
            FUNC_DUMP: if (!empty) state_d = S_DUMP;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POP:    if (pend_q) state_d = S_IDLE;
      S_GATHER: if (walk_done) state_d = S_COPY;
      S_COPY:   if (walk_done) state_d = S_IDLE;
      S_DUMP:   if (walk_done) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    step_d     = step_q;
    pos_d      = pos_q;
    odd_d      = odd_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    plast_d    = plast_q;
    res_vld_d  = 1'b0;
    res_data_d = '0;
    res_st_d   = STATUS_OK;
    res_last_d = 1'b1;
    ring_we    = 1'b0;
    ring_waddr = slot;
    ring_wdata = DATA_WIDTH'(value_i);
    ring_re    = 1'b0;
    ring_raddr = slot;
    scr_we     = 1'b0;
    scr_waddr  = pidx_q;
    scr_wdata  = ring_rdata;
    scr_re     = 1'b0;
    scr_raddr  = step_q[IDX_W-1:0];
    slot_pos   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              res_vld_d = 1'b1;
              if (full) begin
                res_st_d = STATUS_FULL;
              end else begin
                if (func_i == FUNC_PUSH_FRONT) begin
                  slot_pos = IDX_W'(DEPTH - 1);
                  front_d  = slot;
                end else begin
                  slot_pos = count_q[IDX_W-1:0];
                end
                ring_we = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
              if (empty) begin
                res_vld_d = 1'b1;
                res_st_d  = STATUS_EMPTY;
              end else begin
                ring_re = 1'b1;
                pend_d  = 1'b1;
                count_d = count_q - CNT_W'(1);
                if (func_i == FUNC_POP_FRONT) begin
                  // read the front slot directly, adder advances the front
                  ring_raddr = front_q;
                  slot_pos   = IDX_W'(1);
                  front_d    = slot;
                end else begin
                  slot_pos = IDX_W'(count_q - CNT_W'(1));
                end
              end
            end
            FUNC_REORDER: begin
              if (count_q > CNT_W'(2)) begin
                step_d = '0;
                pos_d  = '0;
                odd_d  = 1'b0;
              end else begin
                res_vld_d = 1'b1;
              end
            end
            FUNC_DUMP: begin
              if (empty) begin
                res_vld_d = 1'b1;
                res_st_d  = STATUS_EMPTY;
              end else begin
                step_d = '0;
              end
            end
            default: res_vld_d = 1'b1;
          endcase
        end
      end

      S_POP: begin
        if (pend_q) begin
          res_vld_d  = 1'b1;
          res_data_d = ext_word(ring_rdata);
        end
      end

      S_GATHER: begin
        // even positions ascending, then odd positions descending
        if (pend_q) begin
          scr_we = 1'b1;
        end
        if (step_q != count_q) begin
          slot_pos = pos_q[IDX_W-1:0];
          ring_re  = 1'b1;
          pend_d   = 1'b1;
          pidx_d   = step_q[IDX_W-1:0];
          step_d   = step_q + CNT_W'(1);
          if (odd_q) begin
            pos_d = pos_q - POS_W'(2);
          end else if ((pos_q + POS_W'(2)) < cnt_ext) begin
            pos_d = pos_q + POS_W'(2);
          end else begin
            pos_d = hi_odd;
            odd_d = 1'b1;
          end
        end else if (!pend_q) begin
          step_d = '0;
        end
      end

      S_COPY: begin
        if (pend_q) begin
          ring_we    = 1'b1;
          ring_waddr = pidx_q;
          ring_wdata = scr_rdata;
        end
        if (step_q != count_q) begin
          scr_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = step_q[IDX_W-1:0];
          step_d = step_q + CNT_W'(1);
        end else if (!pend_q) begin
          front_d   = '0;
          res_vld_d = 1'b1;
        end
      end

      S_DUMP: begin
        if (pend_q) begin
          res_vld_d  = 1'b1;
          res_data_d = ext_word(ring_rdata);
          res_last_d = plast_q;
        end
        if (step_q != count_q) begin
          slot_pos = step_q[IDX_W-1:0];
          ring_re  = 1'b1;
          pend_d   = 1'b1;
          plast_d  = ((step_q + CNT_W'(1)) == count_q);
          step_d   = step_q + CNT_W'(1);
        end
      end

      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      step_q    <= '0;
      odd_q     <= 1'b0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      step_q    <= step_d;
      odd_q     <= odd_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    pidx_q     <= pidx_d;
    plast_q    <= plast_d;
    res_data_q <= res_data_d;
    res_st_q   <= res_st_d;
    res_last_q <= res_last_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign valid_o  = res_vld_q;
  assign data_o   = res_data_q;
  assign count_o  = COUNT_W'(count_q);
  assign status_o = res_st_q;
  assign last_o   = res_last_q;

  // Checks
  `CDAR_ASSERT_NOW(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH))
  `CDAR_ASSERT_NOW(a_pend_busy, clk_i, rst_ni, pend_q, state_q != S_IDLE)
  `CDAR_ASSERT_NEXT(a_push_result, clk_i, rst_ni,
    accept && (func_i == FUNC_PUSH_FRONT || func_i == FUNC_PUSH_BACK),
    valid_o && last_o)
  `CDAR_ASSERT_NEXT(a_reorder_front, clk_i, rst_ni,
    state_q == S_COPY && state_d == S_IDLE, front_q == '0 && valid_o)

endmodule

`default_nettype wire
